>>> rtl/ndpot_pkg.sv
// package for the neighbor delay and period offset table
// widths, status codes and state machine type; no dependencies
`timescale 1ns / 1ps
package ndpot_pkg;
    localparam int unsigned DEFAULT_TABLE_DEPTH = 16;
    localparam int unsigned TICK_W = 32;
    localparam int unsigned NBR_W = 16;
    localparam int unsigned SUM_W = 50;
    localparam int unsigned CNT_W = 16;
    localparam int unsigned AVG_W = 34;
    localparam int unsigned OFF_W = 36;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned IDX_W = 4;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CNT_W-1:0] MAX_SAMPLES = '1;

    localparam logic [CFG_ADDR_W-1:0] CFG_NEXT_PERIOD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CYCLE_START = 1'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DELAY_UPD   = 3'd0,
        ST_DELAY_INS   = 3'd1,
        ST_DELAY_FULL  = 3'd2,
        ST_UNKNOWN     = 3'd3,
        ST_OFFSET_UPD  = 3'd4,
        ST_OFFSET_INS  = 3'd5,
        ST_OFFSET_FULL = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSCAN,
        S_DIV,
        S_OSCAN,
        S_WRITE,
        S_DONE
    } state_t;
endpackage

>>> rtl/ndpot_ram.sv
// generic single-port write, single-port read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module ndpot_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/ndpot_div.sv
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// uses ndpot_pkg
`timescale 1ns / 1ps
module ndpot_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic signed [ndpot_pkg::SUM_W-1:0] dividend,
    input  logic [ndpot_pkg::CNT_W-1:0]        divisor,
    output logic                              done,
    output logic signed [ndpot_pkg::AVG_W-1:0] quotient
);
    import ndpot_pkg::*;

    localparam int unsigned STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  q_reg, q_next;
    logic [CNT_W:0]    r_reg, r_next;
    logic [CNT_W-1:0]  d_reg, d_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [CNT_W:0]    trial;
    logic [SUM_W-1:0]  q_signed;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        trial = {r_reg[CNT_W-1:0], q_reg[SUM_W-1]};
        done = 1'b0;
        if (go)
        begin
            neg_next = dividend[SUM_W-1];
            q_next = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
            r_next = '0;
            d_next = divisor;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done = 1'b1;
            end
        end
    end

    assign q_signed = neg_reg ? SUM_W'(-q_next) : q_next;
    assign quotient = q_signed[AVG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end
endmodule

>>> rtl/neighbor_delay_and_period_offset_table_core.sv
// neighbor delay and period offset table top level; uses ndpot_pkg, ndpot_ram, ndpot_div
// an unknown neighbor, a full delay table or a saturated count ends after the delay scan
// with no write; a delay insert writes the delay table; a delay update runs the serial
// divider before its write; a sync item scans the offset table too and writes it unless it
// is new and that table is full; one item at a time, busy until the strobe; no receiver stall
// reset clears valid bits, fill counts and configuration; memories are not cleared
`timescale 1ns / 1ps
module neighbor_delay_and_period_offset_table_core #(
    parameter int unsigned TABLE_DEPTH = ndpot_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ndpot_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  logic [ndpot_pkg::TICK_W-1:0]         cfg_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 kind,
    input  logic [ndpot_pkg::NBR_W-1:0]          sender,
    input  logic [ndpot_pkg::TICK_W-1:0]         echo_send_tick,
    input  logic [ndpot_pkg::TICK_W-1:0]         remote_arrival_tick,
    input  logic [ndpot_pkg::TICK_W-1:0]         remote_send_tick,
    input  logic [ndpot_pkg::TICK_W-1:0]         now_tick,
    input  logic signed [ndpot_pkg::TICK_W-1:0]  announced_interval,
    input  logic [ndpot_pkg::TICK_W-1:0]         announced_duration,
    output logic                                 result_valid,
    output logic [ndpot_pkg::STATUS_W-1:0]       status,
    output logic [ndpot_pkg::IDX_W-1:0]          entry_index,
    output logic signed [ndpot_pkg::AVG_W-1:0]   average_delay_half_ticks,
    output logic [ndpot_pkg::CNT_W-1:0]          sample_count,
    output logic signed [ndpot_pkg::OFF_W-1:0]   period_offset_half_ticks
);
    import ndpot_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned FW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned DW = NBR_W + SUM_W + CNT_W + AVG_W;
    localparam int unsigned OW = NBR_W + OFF_W + TICK_W;

    state_t state_reg, state_next;

    logic [TICK_W-1:0] next_period_reg, cycle_start_reg;
    logic [TABLE_DEPTH-1:0] dvalid_reg, ovalid_reg;
    logic [FW-1:0] dfill_reg, ofill_reg;

    // captured item
    logic              kind_reg;
    logic [NBR_W-1:0]  who_reg;
    logic signed [SUM_W-1:0] rt_reg;
    logic signed [OFF_W-1:0] base_reg;
    logic [TICK_W-1:0] dur_reg;

    // scan control
    logic [FW-1:0] scan_reg, scan_next;
    logic          rd_pend_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          found_reg, found_next;
    logic [AW-1:0] hit_reg, hit_next;
    logic [DW-1:0] dhit_reg;

    // result fields
    logic [STATUS_W-1:0]     st_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [AVG_W-1:0] avg_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [OFF_W-1:0] off_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    wr_d_reg, wr_o_reg;
    logic [AW-1:0]           wslot_reg;

    // memories
    logic          d_we, o_we;
    logic [AW-1:0] d_raddr, o_raddr;
    logic [DW-1:0] d_wdata, d_rdata;
    logic [OW-1:0] o_wdata, o_rdata;

    logic                    div_go, div_done;
    logic signed [AVG_W-1:0] div_q;
    logic                    div_go_reg;

    logic [NBR_W-1:0]        d_rnbr, o_rnbr;
    logic signed [SUM_W-1:0] hit_sum;
    logic [CNT_W-1:0]        hit_cnt;
    logic signed [AVG_W-1:0] hit_avg;
    logic                    accept;
    logic                    rd_match;
    logic [TABLE_DEPTH-1:0]  cur_valid;
    logic                    scan_end;

    assign accept = start && !busy;
    assign busy = (state_reg != S_IDLE);
    assign d_rnbr = d_rdata[DW-1 -: NBR_W];
    assign o_rnbr = o_rdata[OW-1 -: NBR_W];
    assign hit_sum = dhit_reg[SUM_W+CNT_W+AVG_W-1 -: SUM_W];
    assign hit_cnt = dhit_reg[CNT_W+AVG_W-1 -: CNT_W];
    assign hit_avg = dhit_reg[AVG_W-1:0];
    assign cur_valid = (state_reg == S_OSCAN) ? ovalid_reg : dvalid_reg;
    assign rd_match = rd_pend_reg && cur_valid[rd_idx_reg] &&
                      (((state_reg == S_OSCAN) ? o_rnbr : d_rnbr) == who_reg);

    ndpot_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_dram (
        .clk(clk), .we(d_we), .waddr(wslot_reg), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata)
    );
    ndpot_ram #(.WIDTH(OW), .DEPTH(TABLE_DEPTH)) u_oram (
        .clk(clk), .we(o_we), .waddr(wslot_reg), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata)
    );
    ndpot_div u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(sum_reg),
        .divisor(cnt_reg), .done(div_done), .quotient(div_q)
    );

    assign d_raddr = scan_reg[AW-1:0];
    assign o_raddr = scan_reg[AW-1:0];
    assign d_we = (state_reg == S_WRITE) && wr_d_reg;
    assign o_we = (state_reg == S_WRITE) && wr_o_reg;
    assign d_wdata = {who_reg, sum_reg, cnt_reg, avg_reg};
    assign o_wdata = {who_reg, off_reg, dur_reg};
    // divider go is the registered launch flag, raised on entry to S_DIV, once sum and count are registered
    assign div_go = div_go_reg;

    assign scan_end = (scan_reg == FW'(TABLE_DEPTH)) && !rd_pend_reg;

    // scan bookkeeping
    always_comb
    begin
        scan_next = scan_reg;
        found_next = found_reg;
        hit_next = hit_reg;
        if (accept)
        begin
            scan_next = '0;
            found_next = 1'b0;
        end
        else if (state_reg == S_DSCAN || state_reg == S_OSCAN)
        begin
            if (rd_match && !found_reg)
            begin
                found_next = 1'b1;
                hit_next = rd_idx_reg;
            end
            if (scan_reg < FW'(TABLE_DEPTH))
            begin
                scan_next = scan_reg + 1'b1;
            end
            // sync item with a known neighbor goes on to the offset table
            if (state_reg == S_DSCAN && scan_end && kind_reg && found_reg)
            begin
                scan_next = '0;
                found_next = 1'b0;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DSCAN;
                end
            end
            S_DSCAN:
            begin
                if (scan_end)
                begin
                    if (kind_reg)
                    begin
                        state_next = found_reg ? S_OSCAN : S_DONE;
                    end
                    else if (found_reg)
                    begin
                        state_next = (hit_cnt != MAX_SAMPLES) ? S_DIV : S_DONE;
                    end
                    else
                    begin
                        state_next = (dfill_reg >= FW'(TABLE_DEPTH)) ? S_DONE : S_WRITE;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_OSCAN:
            begin
                if (scan_end)
                begin
                    state_next = (found_reg || ofill_reg < FW'(TABLE_DEPTH)) ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        result_valid = (state_reg == S_DONE);
        status = st_reg;
        entry_index = idx_reg;
        average_delay_half_ticks = avg_reg;
        sample_count = cnt_reg;
        period_offset_half_ticks = off_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            next_period_reg <= '0;
            cycle_start_reg <= '0;
            dvalid_reg <= '0;
            ovalid_reg <= '0;
            dfill_reg <= '0;
            ofill_reg <= '0;
            scan_reg <= '0;
            rd_pend_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == CFG_NEXT_PERIOD)
            begin
                next_period_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_CYCLE_START)
            begin
                cycle_start_reg <= cfg_data;
            end
            scan_reg <= scan_next;
            found_reg <= found_next;
            rd_pend_reg <= (state_reg == S_DSCAN || state_reg == S_OSCAN) &&
                           (scan_reg < FW'(TABLE_DEPTH));
            if (d_we && !found_reg)
            begin
                dvalid_reg[wslot_reg] <= 1'b1;
                dfill_reg <= dfill_reg + 1'b1;
            end
            if (o_we && !found_reg)
            begin
                ovalid_reg[wslot_reg] <= 1'b1;
                ofill_reg <= ofill_reg + 1'b1;
            end
        end
    end

    logic signed [SUM_W-1:0] t4s, t1s, t3s, t2s;
    logic signed [OFF_W-1:0] el, rem;
    assign t1s = SUM_W'(echo_send_tick);
    assign t2s = SUM_W'(remote_arrival_tick);
    assign t3s = SUM_W'(remote_send_tick);
    assign t4s = SUM_W'(now_tick);
    assign el = OFF_W'(now_tick) - OFF_W'(cycle_start_reg);
    assign rem = OFF_W'(next_period_reg) - el;

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_reg[AW-1:0];
        hit_reg <= hit_next;
        if (rd_match && !found_reg)
        begin
            dhit_reg <= d_rdata;
        end
        if (accept)
        begin
            kind_reg <= kind;
            who_reg <= sender;
            rt_reg <= (t4s - t1s) - (t3s - t2s);
            base_reg <= (OFF_W'(announced_interval) <<< 1) - (rem <<< 1);
            dur_reg <= announced_duration;
            st_reg <= ST_DELAY_FULL;
            idx_reg <= '0;
            avg_reg <= '0;
            cnt_reg <= '0;
            off_reg <= '0;
            wr_d_reg <= 1'b0;
            wr_o_reg <= 1'b0;
        end
        if (state_reg == S_DSCAN && scan_end)
        begin
            if (kind_reg)
            begin
                if (found_reg)
                begin
                    avg_reg <= hit_avg;
                    cnt_reg <= hit_cnt;
                    off_reg <= base_reg - OFF_W'(hit_avg);
                end
                else
                begin
                    st_reg <= ST_UNKNOWN;
                end
            end
            else if (found_reg)
            begin
                st_reg <= ST_DELAY_UPD;
                idx_reg <= IDX_W'(hit_reg);
                wslot_reg <= hit_reg;
                wr_d_reg <= 1'b1;
                sum_reg <= hit_sum + rt_reg;
                cnt_reg <= (hit_cnt != MAX_SAMPLES) ? hit_cnt + 1'b1 : hit_cnt;
                avg_reg <= hit_avg;
            end
            else if (dfill_reg < FW'(TABLE_DEPTH))
            begin
                st_reg <= ST_DELAY_INS;
                idx_reg <= IDX_W'(dfill_reg);
                wslot_reg <= dfill_reg[AW-1:0];
                wr_d_reg <= 1'b1;
                sum_reg <= rt_reg;
                cnt_reg <= CNT_W'(1);
                avg_reg <= rt_reg[AVG_W-1:0];
            end
        end
        if (state_reg == S_DIV && div_done)
        begin
            avg_reg <= div_q;
        end
        if (state_reg == S_OSCAN && scan_end)
        begin
            if (found_reg)
            begin
                st_reg <= ST_OFFSET_UPD;
                idx_reg <= IDX_W'(hit_reg);
                wslot_reg <= hit_reg;
                wr_o_reg <= 1'b1;
            end
            else if (ofill_reg < FW'(TABLE_DEPTH))
            begin
                st_reg <= ST_OFFSET_INS;
                idx_reg <= IDX_W'(ofill_reg);
                wslot_reg <= ofill_reg[AW-1:0];
                wr_o_reg <= 1'b1;
            end
            else
            begin
                st_reg <= ST_OFFSET_FULL;
            end
        end
    end

    // divider launch when the delay scan of a delay item ends on an unsaturated hit
    logic div_launch;
    assign div_launch = (state_reg == S_DSCAN) && (state_next == S_DIV);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_go_reg <= 1'b0;
        end
        else
        begin
            div_go_reg <= div_launch;
        end
    end
endmodule

>>> rtl/ndpot_checker.sv
// port-level checks for the neighbor delay and period offset table
// uses ndpot_pkg; bound to the top level
`timescale 1ns / 1ps
module ndpot_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              result_valid,
    input logic [ndpot_pkg::STATUS_W-1:0]    status,
    input logic [ndpot_pkg::IDX_W-1:0]       entry_index,
    input logic [ndpot_pkg::CNT_W-1:0]       sample_count,
    input logic signed [ndpot_pkg::OFF_W-1:0] period_offset_half_ticks
);
    import ndpot_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not raise busy");

    a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !busy) else $error("busy after result");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy) else $error("result while idle");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status <= ST_OFFSET_FULL)) else $error("bad status");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == ST_DELAY_FULL || status == ST_UNKNOWN)) |->
        (entry_index == '0 && sample_count == '0 && period_offset_half_ticks == '0))
        else $error("fields not cleared");
endmodule

bind neighbor_delay_and_period_offset_table_core ndpot_checker u_ndpot_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .result_valid(result_valid), .status(status), .entry_index(entry_index),
    .sample_count(sample_count), .period_offset_half_ticks(period_offset_half_ticks)
);
